// ===== sv/rcfb_pkg.sv =====
package rcfb_pkg;

    localparam int unsigned CH_PER_ROBOT = 4;

    localparam logic [7:0]  HDR0    = 8'h24;
    localparam logic [7:0]  HDR1    = 8'h50;
    localparam logic [15:0] VAL_MIN = 16'd1000;
    localparam logic [15:0] VAL_MAX = 16'd2000;
    localparam logic [15:0] VAL_MID = 16'd1500;

    typedef enum logic {
        KIND_SET  = 1'b0,
        KIND_SEND = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CH_YAW      = 2'd0,
        CH_ROLL     = 2'd1,
        CH_PITCH    = 2'd2,
        CH_THROTTLE = 2'd3
    } t_chan;

    // value held by an entry that was never written
    function automatic logic [15:0] reset_value(input logic [1:0] ch);
        logic [15:0] v;
        v = (ch == CH_THROTTLE) ? VAL_MIN : VAL_MID;
        return v;
    endfunction

    // stored value as it goes out on the link
    function automatic logic [15:0] sent_value(input logic [15:0] stored,
                                               input logic [1:0]  ch);
        logic [15:0] v;
        if (stored >= VAL_MIN && stored <= VAL_MAX) begin
            v = stored;
        end else begin
            v = (ch == CH_YAW) ? VAL_MIN : VAL_MID;
        end
        return v;
    endfunction

endpackage

// ===== sv/rc_channel_frame_builder_unit.sv =====
// RC channel frame builder.
// Input channel (i_valid / o_ready): one beat is either a set command that
// writes one 16-bit channel of one robot slot, or a send command.
// A set beat gives no output; writes to a robot slot at or above
// NUM_ROBOTS are dropped.
// A send beat produces 3 + 8 * NUM_ROBOTS output beats (35 for four robots)
// on o_valid / i_ready: '$', 'P', each channel low byte then high byte,
// robot by robot, and an XOR checksum with o_last set.
// The channel values sit in a small synchronous RAM; a frame streams one
// byte per cycle while the receiver is ready, because the read address is
// taken from the next byte counter, so the registered read data is ready
// when its byte is due. The next command is accepted once the last byte is
// in the output register.
// Reset clears the per-entry valid bits, so every channel reads back as
// its default (throttle 1000, others 1500) until written; no clearing pass.
// When the receiver stalls, the output register holds its beat and the
// byte sequencer waits.
module rc_channel_frame_builder_unit #(
    parameter int unsigned NUM_ROBOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [1:0]  i_robot,
    input  logic [1:0]  i_channel,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_last
);

    localparam int unsigned Depth = NUM_ROBOTS * rcfb_pkg::CH_PER_ROBOT;
    localparam int unsigned AW    = $clog2(Depth);
    localparam int unsigned NB    = 3 + 2 * Depth;
    localparam int unsigned IW    = $clog2(NB);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic [7:0]      r_sum;
    logic            r_o_valid;
    logic [7:0]      r_o_byte;
    logic            r_o_last;

    logic [15:0]     r_mem [Depth];
    logic [Depth-1:0] r_vld;
    logic [15:0]     r_rd_data;
    logic            r_rd_vld;
    logic [1:0]      r_rd_ch;

    logic            in_acc;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            advance;
    logic [IW-1:0]   off;
    logic [15:0]     cur_val;
    logic [7:0]      byte_d;
    logic            is_last;

    assign o_ready      = (r_state == ST_IDLE);
    assign in_acc       = i_valid && o_ready;
    assign wr_en        = in_acc && (i_kind == rcfb_pkg::KIND_SET)
                          && ({1'b0, i_robot} < 3'(NUM_ROBOTS));
    assign wr_addr      = AW'({i_robot, i_channel});

    assign o_valid      = r_o_valid;
    assign o_frame_byte = r_o_byte;
    assign o_last       = r_o_last;

    assign advance = (r_state == ST_SEND) && (!r_o_valid || i_ready);
    assign is_last = (r_idx == IW'(NB - 1));
    assign off     = r_idx - IW'(2);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (in_acc && i_kind == rcfb_pkg::KIND_SEND) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (advance) begin
                    if (is_last) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    // address the entry of the byte that will be current next cycle
    always_comb begin
        logic [IW-1:0] noff;
        noff = n_idx - IW'(2);
        if (n_idx >= IW'(2) && n_idx < IW'(NB - 1)) begin
            rd_addr = AW'(noff >> 1);
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
        r_rd_ch   <= rd_addr[1:0];
    end

    always_comb begin
        logic [15:0] stored;
        stored  = r_rd_vld ? r_rd_data : rcfb_pkg::reset_value(r_rd_ch);
        cur_val = rcfb_pkg::sent_value(stored, r_rd_ch);
        if (r_idx == IW'(0)) begin
            byte_d = rcfb_pkg::HDR0;
        end else if (r_idx == IW'(1)) begin
            byte_d = rcfb_pkg::HDR1;
        end else if (is_last) begin
            byte_d = r_sum;
        end else if (off[0]) begin
            byte_d = cur_val[15:8];
        end else begin
            byte_d = cur_val[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_vld     <= '0;
            r_o_valid <= 1'b0;
            r_sum     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == ST_IDLE) begin
                r_sum <= '0;
            end else if (advance && r_idx >= IW'(2) && !is_last) begin
                r_sum <= r_sum ^ byte_d;
            end
        end
    end

    // payload of the output beat
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_byte <= byte_d;
            r_o_last <= is_last;
        end
    end

endmodule

// ===== tb/sv/rc_channel_frame_builder_unit_test.sv =====
`timescale 1ns / 100ps

class frame_scoreboard;
    localparam int unsigned ROBOTS = 4;

    logic [15:0] channel_mem [ROBOTS * rcfb_pkg::CH_PER_ROBOT];
    logic [8:0]  frame_bytes_due [$];   // {last, byte}
    int unsigned bad_beats;

    function new();
        for (int r = 0; r < ROBOTS; r++) begin
            for (int c = 0; c < rcfb_pkg::CH_PER_ROBOT; c++) begin
                channel_mem[r * rcfb_pkg::CH_PER_ROBOT + c] =
                    (c == rcfb_pkg::CH_THROTTLE) ? rcfb_pkg::VAL_MIN : rcfb_pkg::VAL_MID;
            end
        end
        bad_beats = 0;
    endfunction

    function void note_command(input logic kind, input logic [1:0] robot,
                               input logic [1:0] chan, input logic [15:0] value);
        logic [15:0] v;
        logic [7:0]  csum;
        csum = 8'h00;
        if (kind == rcfb_pkg::KIND_SET) begin
            if (robot < ROBOTS) begin
                channel_mem[robot * rcfb_pkg::CH_PER_ROBOT + chan] = value;
            end
            return;
        end
        frame_bytes_due.push_back({1'b0, rcfb_pkg::HDR0});
        frame_bytes_due.push_back({1'b0, rcfb_pkg::HDR1});
        for (int r = 0; r < ROBOTS; r++) begin
            for (int c = 0; c < rcfb_pkg::CH_PER_ROBOT; c++) begin
                v = channel_mem[r * rcfb_pkg::CH_PER_ROBOT + c];
                // out-of-range values go out as 1000 on yaw and 1500 on the other channels
                if (v < rcfb_pkg::VAL_MIN || v > rcfb_pkg::VAL_MAX) begin
                    v = (c == rcfb_pkg::CH_YAW) ? rcfb_pkg::VAL_MIN : rcfb_pkg::VAL_MID;
                end
                frame_bytes_due.push_back({1'b0, v[7:0]});
                frame_bytes_due.push_back({1'b0, v[15:8]});
                csum = csum ^ v[7:0] ^ v[15:8];
            end
        end
        frame_bytes_due.push_back({1'b1, csum});
    endfunction

    function void check_byte(input logic [7:0] data, input logic last);
        logic [8:0] want;
        if (frame_bytes_due.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10) begin
                $display("unexpected beat: byte %02h last %b", data, last);
            end
            return;
        end
        want = frame_bytes_due.pop_front();
        if (want[7:0] !== data || want[8] !== last) begin
            bad_beats++;
            if (bad_beats <= 10) begin
                $display("beat differs: expected byte %02h last %b, got byte %02h last %b",
                         want[7:0], want[8], data, last);
            end
        end
    endfunction
endclass

module rc_channel_frame_builder_unit_test;
    localparam int unsigned ROBOTS         = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES    = 40;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        i_kind    = rcfb_pkg::KIND_SET;
    logic [1:0]  i_robot   = 2'd0;
    logic [1:0]  i_channel = rcfb_pkg::CH_YAW;
    logic [15:0] i_value   = 16'd0;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_frame_byte;
    logic        o_last;

    frame_scoreboard sb = new();
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    rc_channel_frame_builder_unit #(
        .NUM_ROBOTS(ROBOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_robot     (i_robot),
        .i_channel   (i_channel),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_frame_byte(o_frame_byte),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic drive_command(input logic kind, input logic [1:0] robot,
                                 input logic [1:0] chan, input logic [15:0] value);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_robot   <= robot;
        i_channel <= chan;
        i_value   <= value;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_command(kind, robot, chan, value);
    endtask

    // hold off the sender until every frame byte has come out
    task automatic wait_frames_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.frame_bytes_due.size() != 0);
    endtask

    // receiver side
    initial begin
        int unsigned gap;
        int unsigned beats;
        beats = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            sb.check_byte(o_frame_byte, o_last);
            beats++;
            if (beats % 50 == 0) begin
                rx_burst = !rx_burst;
            end
        end
    end

    initial begin
        int unsigned idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("rc_channel_frame_builder_unit: mismatch");
        $finish;
    end

    initial begin
        int unsigned sel;
        logic [15:0] v;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // frame straight out of reset, then range edges on every channel
        drive_command(rcfb_pkg::KIND_SEND, 2'd0, rcfb_pkg::CH_YAW, 16'd0);
        drive_command(rcfb_pkg::KIND_SET, 2'd0, rcfb_pkg::CH_YAW, 16'd0);
        drive_command(rcfb_pkg::KIND_SET, 2'd0, rcfb_pkg::CH_ROLL, 16'hffff);
        drive_command(rcfb_pkg::KIND_SET, 2'd0, rcfb_pkg::CH_PITCH, 16'd999);
        drive_command(rcfb_pkg::KIND_SET, 2'd0, rcfb_pkg::CH_THROTTLE, 16'd2001);
        drive_command(rcfb_pkg::KIND_SET, 2'd1, rcfb_pkg::CH_YAW, 16'd1000);
        drive_command(rcfb_pkg::KIND_SET, 2'd1, rcfb_pkg::CH_ROLL, 16'd2000);
        drive_command(rcfb_pkg::KIND_SET, 2'd1, rcfb_pkg::CH_PITCH, 16'd1999);
        drive_command(rcfb_pkg::KIND_SET, 2'd1, rcfb_pkg::CH_THROTTLE, 16'd1001);
        drive_command(rcfb_pkg::KIND_SET, 2'd2, rcfb_pkg::CH_YAW, 16'h8000);
        drive_command(rcfb_pkg::KIND_SET, 2'd2, rcfb_pkg::CH_THROTTLE, 16'd2000);
        drive_command(rcfb_pkg::KIND_SET, 2'd3, rcfb_pkg::CH_YAW, 16'd2001);
        drive_command(rcfb_pkg::KIND_SET, 2'd3, rcfb_pkg::CH_ROLL, 16'd1000);
        drive_command(rcfb_pkg::KIND_SET, 2'd3, rcfb_pkg::CH_THROTTLE, 16'd999);
        // fields other than kind are don't-care on a send
        drive_command(rcfb_pkg::KIND_SEND, 2'd3, rcfb_pkg::CH_THROTTLE, 16'hffff);
        drive_command(rcfb_pkg::KIND_SET, 2'd2, rcfb_pkg::CH_PITCH, 16'h7fff);
        drive_command(rcfb_pkg::KIND_SEND, 2'd1, rcfb_pkg::CH_ROLL, 16'h5a5a);
        drive_command(rcfb_pkg::KIND_SEND, 2'd2, rcfb_pkg::CH_PITCH, 16'ha5a5);
        wait_frames_drained();

        for (int n = 0; n < 260; n++) begin
            tx_burst = ((n / 40) % 3 == 1);
            if (n == 130) begin
                wait_frames_drained();
            end
            sel = $urandom_range(0, 99);
            if (sel < 16) begin
                drive_command(rcfb_pkg::KIND_SEND, 2'($urandom), 2'($urandom),
                              16'($urandom));
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    v = 16'($urandom_range(rcfb_pkg::VAL_MIN, rcfb_pkg::VAL_MAX));
                end else if (sel < 75) begin
                    v = (sel[0] ? rcfb_pkg::VAL_MIN : rcfb_pkg::VAL_MAX)
                        + 16'($urandom_range(0, 4)) - 16'd2;
                end else begin
                    v = 16'($urandom);
                end
                drive_command(rcfb_pkg::KIND_SET, 2'($urandom), 2'($urandom), v);
            end
        end
        drive_command(rcfb_pkg::KIND_SEND, 2'd0, rcfb_pkg::CH_YAW, 16'd0);

        wait_frames_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.bad_beats == 0 && sb.frame_bytes_due.size() == 0) begin
            $display("rc_channel_frame_builder_unit: match");
        end else begin
            $display("rc_channel_frame_builder_unit: mismatch");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/rcfb_pkg.sv
sv/rc_channel_frame_builder_unit.sv
tb/sv/rc_channel_frame_builder_unit_test.sv
